// ===== design/hmsl_pkg.sv =====
// Package: constants, types and helpers for the min-heap build swap log block.
`default_nettype none

package hmsl_pkg;

    localparam int CAPACITY    = 64;
    localparam int MAX_RESULTS = 63;
    localparam int DATA_W      = 32;
    localparam int IDX_W       = 6;
    localparam int ADDR_W      = $clog2(CAPACITY);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int LR_W        = ADDR_W + 2;
    localparam int RES_W       = $clog2(MAX_RESULTS + 1);
    localparam int S_TDATA_W   = 32;
    localparam int M_TDATA_W   = 16;

    typedef enum logic [3:0] {
        S_LOAD,
        S_START,
        S_SIFT,
        S_RDL,
        S_RDR,
        S_CMPR,
        S_DEC,
        S_SWP,
        S_NEXT,
        S_FIN
    } state_t;

    typedef struct packed {
        logic                     we;
        logic [ADDR_W-1:0]        waddr;
        logic signed [DATA_W-1:0] wdata;
        logic [ADDR_W-1:0]        raddr;
    } mem_req_t;

    // Reported indices are masked/extended to the output index width
    function automatic logic [IDX_W-1:0] to_idx(input logic [ADDR_W-1:0] a);
        logic [ADDR_W+IDX_W-1:0] w;
        w = (ADDR_W+IDX_W)'(a);
        return w[IDX_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== design/hmsl_mem.sv =====
// Element store: one write port, one registered read port.
`default_nettype none

module hmsl_mem
    import hmsl_pkg::*;
(
    input  logic                     clk,
    input  mem_req_t                 req,
    output logic signed [DATA_W-1:0] rd_data
);

    logic signed [DATA_W-1:0] store [CAPACITY];
    logic signed [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            store[req.waddr] <= req.wdata;
        end
        rd_data_reg <= store[req.raddr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== design/hmsl_cmp.sv =====
// Shared signed less-than compare unit.
`default_nettype none

module hmsl_cmp
    import hmsl_pkg::*;
(
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output logic                     lt
);

    assign lt = (a < b);

endmodule

`default_nettype wire

// ===== design/hmsl_ctrl.sv =====
// Sequencer: load, sift-down build, swap log and output register.
`default_nettype none

module hmsl_ctrl
    import hmsl_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic signed [DATA_W-1:0] s_value,
    input  logic                     s_tlast,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [IDX_W-1:0]         m_parent,
    output logic [IDX_W-1:0]         m_child,
    output logic                     m_swap,
    output logic                     m_tlast,
    output mem_req_t                 mem_req,
    input  logic signed [DATA_W-1:0] rd_data,
    output logic signed [DATA_W-1:0] cmp_a,
    output logic signed [DATA_W-1:0] cmp_b,
    input  logic                     cmp_lt
);

    state_t state_reg, state_next;

    logic [CNT_W-1:0]         count_reg;
    logic [ADDR_W-1:0]        p_reg;
    logic [ADDR_W-1:0]        j_reg;
    logic [ADDR_W-1:0]        best_idx_reg;
    logic signed [DATA_W-1:0] best_val_reg;
    logic signed [DATA_W-1:0] jval_reg;
    logic [RES_W-1:0]         k_reg;
    logic                     pend_valid_reg;
    logic [IDX_W-1:0]         pend_parent_reg;
    logic [IDX_W-1:0]         pend_child_reg;

    logic                     out_valid_reg;
    logic [IDX_W-1:0]         out_parent_reg;
    logic [IDX_W-1:0]         out_child_reg;
    logic                     out_swap_reg;
    logic                     out_last_reg;

    logic [LR_W-1:0]          l_idx;
    logic [LR_W-1:0]          r_idx;
    logic [LR_W-1:0]          n_ext;
    logic                     l_ok;
    logic                     r_ok;
    logic                     room;
    logic                     out_free;
    logic                     log_more;
    logic                     swp_go;
    logic                     out_load;
    logic [ADDR_W-1:0]        p_start;

    assign l_idx    = {1'b0, j_reg, 1'b1};
    assign r_idx    = l_idx + LR_W'(1);
    assign n_ext    = LR_W'(count_reg);
    assign l_ok     = (l_idx < n_ext);
    assign r_ok     = (r_idx < n_ext);
    assign room     = (count_reg < CNT_W'(CAPACITY));
    assign out_free = !out_valid_reg || m_tready;
    assign log_more = (k_reg < RES_W'(MAX_RESULTS));
    assign swp_go   = !(log_more && pend_valid_reg && !out_free);
    assign p_start  = count_reg[CNT_W-1:1];
    assign out_load = ((state_reg == S_SWP) && swp_go && log_more && pend_valid_reg)
                   || ((state_reg == S_FIN) && out_free);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (s_tvalid && s_tlast)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = (p_start == '0) ? S_FIN : S_SIFT;
            end
            S_SIFT:
            begin
                state_next = l_ok ? S_RDL : S_NEXT;
            end
            S_RDL:
            begin
                state_next = S_RDR;
            end
            S_RDR:
            begin
                state_next = S_CMPR;
            end
            S_CMPR:
            begin
                state_next = S_DEC;
            end
            S_DEC:
            begin
                state_next = (best_idx_reg == j_reg) ? S_NEXT : S_SWP;
            end
            S_SWP:
            begin
                if (swp_go)
                begin
                    state_next = S_SIFT;
                end
            end
            S_NEXT:
            begin
                state_next = (p_reg == ADDR_W'(1)) ? S_FIN : S_SIFT;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // outputs to store, compare unit and input handshake
    always_comb
    begin
        s_tready      = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.waddr = j_reg;
        mem_req.wdata = best_val_reg;
        mem_req.raddr = j_reg;
        cmp_a         = rd_data;
        cmp_b         = best_val_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                s_tready      = 1'b1;
                mem_req.we    = s_tvalid && room;
                mem_req.waddr = count_reg[ADDR_W-1:0];
                mem_req.wdata = s_value;
            end
            S_RDL:
            begin
                mem_req.raddr = l_idx[ADDR_W-1:0];
            end
            S_RDR:
            begin
                mem_req.raddr = r_idx[ADDR_W-1:0];
                cmp_b         = jval_reg;
            end
            S_DEC:
            begin
                mem_req.we    = (best_idx_reg != j_reg);
            end
            S_SWP:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = best_idx_reg;
                mem_req.wdata = jval_reg;
            end
            default:
            begin
                mem_req.we    = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            k_reg          <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_LOAD:
                begin
                    if (s_tvalid && room)
                    begin
                        count_reg <= count_reg + CNT_W'(1);
                    end
                end
                S_SWP:
                begin
                    if (swp_go && log_more)
                    begin
                        pend_valid_reg <= 1'b1;
                        k_reg          <= k_reg + RES_W'(1);
                    end
                end
                S_FIN:
                begin
                    if (out_free)
                    begin
                        pend_valid_reg <= 1'b0;
                        k_reg          <= '0;
                        count_reg      <= '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_START:
            begin
                p_reg <= p_start;
                j_reg <= p_start - ADDR_W'(1);
            end
            S_RDL:
            begin
                jval_reg <= rd_data;
            end
            S_RDR:
            begin
                if (cmp_lt)
                begin
                    best_idx_reg <= l_idx[ADDR_W-1:0];
                    best_val_reg <= rd_data;
                end
                else
                begin
                    best_idx_reg <= j_reg;
                    best_val_reg <= jval_reg;
                end
            end
            S_CMPR:
            begin
                if (r_ok && cmp_lt)
                begin
                    best_idx_reg <= r_idx[ADDR_W-1:0];
                    best_val_reg <= rd_data;
                end
            end
            S_SWP:
            begin
                if (swp_go)
                begin
                    j_reg <= best_idx_reg;
                    if (log_more)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_parent_reg <= pend_parent_reg;
                            out_child_reg  <= pend_child_reg;
                            out_swap_reg   <= 1'b1;
                            out_last_reg   <= 1'b0;
                        end
                        pend_parent_reg <= to_idx(j_reg);
                        pend_child_reg  <= to_idx(best_idx_reg);
                    end
                end
            end
            S_NEXT:
            begin
                p_reg <= p_reg - ADDR_W'(1);
                j_reg <= p_reg - ADDR_W'(2);
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_last_reg <= 1'b1;
                    if (pend_valid_reg)
                    begin
                        out_parent_reg <= pend_parent_reg;
                        out_child_reg  <= pend_child_reg;
                        out_swap_reg   <= 1'b1;
                    end
                    else
                    begin
                        out_parent_reg <= '0;
                        out_child_reg  <= '0;
                        out_swap_reg   <= 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_parent = out_parent_reg;
    assign m_child  = out_child_reg;
    assign m_swap   = out_swap_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== design/build_min_heap_swap_log_top.sv =====
// Top level: min-heap build over loaded values with a log of the first 63 swaps.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  s_tdata = value, s_tlast = last
//  m_*      out  m_tvalid/m_tready  m_tdata = parent, child; m_tuser = is_swap;
//                                   m_tlast = last_res
//
//  In the load state one value is taken per cycle; s_tready stays low from
//  the last value until the final result is in the output register. A build
//  has a start step, then steps read node, read left, read right, compare and
//  decide per node with children, a check per childless node, a swap step per
//  swap, a next step per parent and a finish step; one store read port and one
//  shared comparator set this pace. A low m_tready stalls the sequencer when a
//  result finds the output register full. Reset is asynchronous, active low.
`default_nettype none

module build_min_heap_swap_log_top
    import hmsl_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] value
    input  logic                 s_tlast,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [5:0] parent_index, [11:6] child_index, [15:12] 0
    output logic                 m_tuser,   // [0] is_swap
    output logic                 m_tlast
);

    mem_req_t                 mem_req;
    logic signed [DATA_W-1:0] rd_data;
    logic signed [DATA_W-1:0] cmp_a;
    logic signed [DATA_W-1:0] cmp_b;
    logic                     cmp_lt;
    logic [IDX_W-1:0]         m_parent;
    logic [IDX_W-1:0]         m_child;

    hmsl_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    hmsl_cmp u_cmp (
        .a  (cmp_a),
        .b  (cmp_b),
        .lt (cmp_lt)
    );

    hmsl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_value  (signed'(s_tdata[DATA_W-1:0])),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_parent (m_parent),
        .m_child  (m_child),
        .m_swap   (m_tuser),
        .m_tlast  (m_tlast),
        .mem_req  (mem_req),
        .rd_data  (rd_data),
        .cmp_a    (cmp_a),
        .cmp_b    (cmp_b),
        .cmp_lt   (cmp_lt)
    );

    assign m_tdata = {(M_TDATA_W - 2*IDX_W)'(0), m_child, m_parent};

endmodule

`default_nettype wire

// ===== design/hmsl_chk.sv =====
// Port checker for the min-heap build swap log block, bound to the top level.
`default_nettype none

module hmsl_chk
    import hmsl_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 s_tlast,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser,
    input logic                 m_tlast
);

    // build starts right after the final value
    a_build_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still ready after final value");

    // a no-swap result is always the only and final one
    a_noswap_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tlast)
        else $error("no-swap result not flagged last");

    // swap moves a parent down to a higher child index
    a_swap_order: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (m_tdata[5:0] < m_tdata[11:6]))
        else $error("swap parent not below child");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled transaction changed");

endmodule

bind build_min_heap_swap_log_top hmsl_chk u_hmsl_chk (.*);

`default_nettype wire

// ===== test/build_min_heap_swap_log_top_test.sv =====
// Testbench for build_min_heap_swap_log_top: directed table, random arrays, swap log scoreboard.
`timescale 1ns / 1ps

module build_min_heap_swap_log_top_test;
    import hmsl_pkg::*;

    typedef struct packed {
        logic [IDX_W-1:0] parent;
        logic [IDX_W-1:0] child;
        logic             is_swap;
        logic             last_res;
    } swap_rec_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              last;
        logic              typed;
        swap_rec_t         result;
    } stim_row_t;

    localparam logic [DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam swap_rec_t NO_SWAP   = '{6'd0, 6'd0, 1'b0, 1'b1};
    localparam swap_rec_t ROOT_LEFT = '{6'd0, 6'd1, 1'b1, 1'b1};
    localparam swap_rec_t ROOT_RGHT = '{6'd0, 6'd2, 1'b1, 1'b1};
    localparam swap_rec_t UNTYPED   = '0;
    localparam int DIR_N        = 26;
    localparam int RAND_ITEMS   = 370 - DIR_N;
    localparam int DRAIN_CYCLES = 100;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // [31:0] value
    logic                 s_tlast;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // [5:0] parent_index, [11:6] child_index, [15:12] 0
    logic                 m_tuser;   // [0] is_swap
    logic                 m_tlast;

    build_min_heap_swap_log_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // predictor state
    logic signed [DATA_W-1:0] heap_store [CAPACITY];
    int                       heap_fill;
    swap_rec_t                fresh_swaps [$];
    swap_rec_t                swaps_expected [$];

    int err_count    = 0;
    int items_accepted;
    int results_seen = 0;
    int swaps_seen   = 0;
    int builds_seen  = 0;
    int full_builds;
    bit rx_calm;

    stim_row_t dir_rows [DIR_N] = '{
        '{VAL_MAX, 1'b1, 1'b1, NO_SWAP},             // one element
        '{VAL_MIN, 1'b1, 1'b1, NO_SWAP},
        '{VAL_MAX, 1'b0, 1'b0, UNTYPED},
        '{VAL_MIN, 1'b1, 1'b1, ROOT_LEFT},           // max over min
        '{VAL_MIN, 1'b0, 1'b0, UNTYPED},
        '{VAL_MAX, 1'b1, 1'b1, NO_SWAP},
        '{32'd5, 1'b0, 1'b0, UNTYPED},
        '{32'd3, 1'b0, 1'b0, UNTYPED},
        '{32'd3, 1'b1, 1'b1, ROOT_LEFT},             // tied children, left wins
        '{32'd0, 1'b0, 1'b0, UNTYPED},
        '{32'hFFFF_FFFF, 1'b0, 1'b0, UNTYPED},
        '{32'd1, 1'b0, 1'b0, UNTYPED},
        '{32'hFFFF_FFFE, 1'b1, 1'b0, UNTYPED},       // sift continues downward
        '{32'd40, 1'b0, 1'b0, UNTYPED},
        '{32'd30, 1'b0, 1'b0, UNTYPED},
        '{32'd20, 1'b0, 1'b0, UNTYPED},
        '{32'd10, 1'b0, 1'b0, UNTYPED},
        '{32'd0, 1'b1, 1'b0, UNTYPED},
        '{32'd7, 1'b0, 1'b0, UNTYPED},
        '{32'd7, 1'b0, 1'b0, UNTYPED},
        '{32'd7, 1'b1, 1'b1, NO_SWAP},               // equal values never swap
        '{32'hAAAA_AAAA, 1'b0, 1'b0, UNTYPED},
        '{32'h5555_5555, 1'b1, 1'b1, NO_SWAP},
        '{32'd9, 1'b0, 1'b0, UNTYPED},
        '{32'd4, 1'b0, 1'b0, UNTYPED},
        '{32'd2, 1'b1, 1'b1, ROOT_RGHT}              // right child smaller
    };

    always #4 clk = ~clk;

    initial begin
        #4_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // bottom-up heapify over the loaded values, logging up to MAX_RESULTS swaps
    function automatic void predict_item(input logic [DATA_W-1:0] v, input logic lst);
        int n;
        int j;
        int l;
        int r;
        int m;
        int k;
        logic signed [DATA_W-1:0] t;
        swap_rec_t rec;
        fresh_swaps.delete();
        if (heap_fill < CAPACITY) begin
            heap_store[heap_fill] = v;
            heap_fill++;
        end
        if (!lst)
            return;
        if (heap_fill == CAPACITY)
            full_builds++;
        n = heap_fill;
        k = 0;
        for (int p = n / 2; p > 0; p--) begin
            j = p - 1;
            while (2 * j + 1 < n) begin
                l = 2 * j + 1;
                r = l + 1;
                m = j;
                if (heap_store[l] < heap_store[m])
                    m = l;
                if (r < n && heap_store[r] < heap_store[m])
                    m = r;
                if (m == j)
                    break;
                t = heap_store[j];
                heap_store[j] = heap_store[m];
                heap_store[m] = t;
                if (k < MAX_RESULTS) begin
                    rec.parent   = IDX_W'(j);
                    rec.child    = IDX_W'(m);
                    rec.is_swap  = 1'b1;
                    rec.last_res = 1'b0;
                    fresh_swaps = {fresh_swaps, rec};
                    k++;
                end
                j = m;
            end
        end
        if (k == 0)
            fresh_swaps = {fresh_swaps, NO_SWAP};
        else
            fresh_swaps[k-1].last_res = 1'b1;
        heap_fill = 0;
    endfunction

    task automatic send_item(input logic [DATA_W-1:0] v, input logic lst, input int gap,
                             input logic typed, input swap_rec_t typed_rec);
        @(negedge clk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = v;
        s_tlast  = lst;
        do
            @(posedge clk);
        while (!s_tready);
        items_accepted++;
        predict_item(v, lst);
        if (typed)
            fresh_swaps = {typed_rec};
        swaps_expected = {swaps_expected, fresh_swaps};
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (swaps_expected.size() != 0)
            @(posedge clk);
    endtask

    // result side: random tready stalls, with calm stretches
    initial begin
        int stall;
        rx_calm  = 1'b0;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 23) == 0)
                rx_calm = ~rx_calm;
            stall = rx_calm ? 0 : $urandom_range(0, 15);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    always @(posedge clk) begin
        swap_rec_t want;
        if (rst_n && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser)
                swaps_seen++;
            if (m_tlast)
                builds_seen++;
            if (swaps_expected.size() == 0) begin
                $error("unexpected result transaction: tdata=%h tuser=%b tlast=%b",
                       m_tdata, m_tuser, m_tlast);
                err_count++;
            end else begin
                want = swaps_expected.pop_front();
                if (m_tdata[5:0] !== want.parent) begin
                    $error("parent_index: expected %0d, got %0d", want.parent, m_tdata[5:0]);
                    err_count++;
                end
                if (m_tdata[11:6] !== want.child) begin
                    $error("child_index: expected %0d, got %0d", want.child, m_tdata[11:6]);
                    err_count++;
                end
                if (m_tuser !== want.is_swap) begin
                    $error("is_swap: expected %0b, got %0b", want.is_swap, m_tuser);
                    err_count++;
                end
                if (m_tlast !== want.last_res) begin
                    $error("last_res: expected %0b, got %0b", want.last_res, m_tlast);
                    err_count++;
                end
            end
        end
    end

    initial begin
        int sent;
        int arr_len;
        int vmode;
        int sv;
        int narr;
        bit burst;
        logic [DATA_W-1:0] v;

        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        heap_fill      = 0;
        items_accepted = 0;
        full_builds    = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < DIR_N; i++)
            send_item(dir_rows[i].value, dir_rows[i].last, $urandom_range(0, 15),
                      dir_rows[i].typed, dir_rows[i].result);

        // hold the sender off until the whole log so far has been returned
        wait_drained();

        sent = 0;
        narr = 0;
        while (sent < RAND_ITEMS) begin
            if (narr == 0)
                arr_len = CAPACITY + 6;
            else if (narr == 1)
                arr_len = CAPACITY;
            else if ($urandom_range(0, 19) == 0)
                arr_len = $urandom_range(CAPACITY - 4, CAPACITY + 4);
            else
                arr_len = $urandom_range(1, 14);
            vmode = $urandom_range(0, 3);
            burst = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0)
                wait_drained();
            for (int i = 0; i < arr_len; i++) begin
                case (vmode)
                    0: begin
                        sv = int'($urandom_range(0, 6)) - 3;
                        v  = sv;
                    end
                    1: begin
                        case ($urandom_range(0, 3))
                            0: v = VAL_MIN;
                            1: v = VAL_MAX;
                            2: v = '0;
                            default: v = '1;
                        endcase
                    end
                    default: v = $urandom;
                endcase
                send_item(v, i == arr_len - 1, burst ? 0 : $urandom_range(0, 15),
                          1'b0, UNTYPED);
            end
            sent += arr_len;
            narr++;
        end

        @(negedge clk);
        s_tvalid = 1'b0;
        while (swaps_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run: %0d values loaded, %0d heap builds (%0d over a full store)",
                 items_accepted, builds_seen, full_builds);
        $display("     %0d log transactions checked, %0d of them swaps",
                 results_seen, swaps_seen);
        if (err_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/hmsl_pkg.sv
design/hmsl_mem.sv
design/hmsl_cmp.sv
design/hmsl_ctrl.sv
design/build_min_heap_swap_log_top.sv
design/hmsl_chk.sv
test/build_min_heap_swap_log_top_test.sv
